FILE: hdl/rrh_pkg.sv
// Package for the retransmit request holdoff block: sizes, codes and payload types.
`default_nettype none

package rrh_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    localparam int BLOCK_W       = 21;
    localparam int TIME_W        = 32;
    localparam int COUNT_W       = 16;
    localparam int OUTCOME_W     = 3;
    localparam int CFG_W         = 8;
    localparam int CFG_INDEX_W   = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [CFG_INDEX_W-1:0] REG_HOLDOFF = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_EXPIRE  = 2'd1;

    localparam logic [CFG_W-1:0] HOLDOFF_RESET = 8'd5;
    localparam logic [CFG_W-1:0] EXPIRE_RESET  = 8'd10;

    localparam logic [OUTCOME_W-1:0] OUT_RANGE      = 3'd0;
    localparam logic [OUTCOME_W-1:0] OUT_NEW        = 3'd1;
    localparam logic [OUTCOME_W-1:0] OUT_RESENT     = 3'd2;
    localparam logic [OUTCOME_W-1:0] OUT_SUPPRESSED = 3'd3;
    localparam logic [OUTCOME_W-1:0] OUT_FULL       = 3'd4;

    typedef struct packed {
        logic [BLOCK_W-1:0] block_index;
        logic [TIME_W-1:0]  now_seconds;
        logic [BLOCK_W-1:0] highest_sent;
    } req_t;

    typedef struct packed {
        logic                 send_now;
        logic [BLOCK_W-1:0]   block_out;
        logic [COUNT_W-1:0]   report_count;
        logic [OUTCOME_W-1:0] outcome;
    } rsp_t;

    typedef struct packed {
        logic [BLOCK_W-1:0] block;
        logic [TIME_W-1:0]  sent_time;
        logic [COUNT_W-1:0] reports;
    } slot_entry_t;

    typedef struct packed {
        logic              live;
        logic              match;
        logic [TIME_W-1:0] age;
    } slot_cmp_t;

endpackage

`default_nettype wire

FILE: hdl/retransmit_request_holdoff.sv
// Top level of the retransmit request holdoff block.
// Each request looks up its block in a 64-slot table of recent reports and
// returns one decision (send, suppress, new entry, table full or out of
// range). A request whose block lies above highest_sent skips the table scan
// and goes straight to the response step; any other request streams the slot
// memory through one age/match compare unit, then takes a decide and
// write-back step and a load of the response register. The slot memory port
// and the single compare unit mean the slots are compared one at a time; the
// request side is stalled while a request is in work. A finished response waits in its
// output register, and the next request is taken meanwhile. Configuration
// writes are always ready.
`default_nettype none

module retransmit_request_holdoff (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               req_valid,
    output logic                                    req_stall,
    input  wire rrh_pkg::req_t                      req_data,

    output logic                                    rsp_valid,
    input  wire logic                               rsp_stall,
    output rrh_pkg::rsp_t                           rsp_data,

    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [rrh_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [rrh_pkg::CFG_W-1:0]          cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DECIDE = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    state_t                              state_reg, state_next;
    logic [rrh_pkg::CNT_W-1:0]           rd_cnt_reg, rd_cnt_next;
    logic                                cmp_pending_reg, cmp_pending_next;
    logic                                hit_found_reg, hit_found_next;
    logic                                free_found_reg, free_found_next;
    logic                                rsp_valid_reg, rsp_valid_next;
    logic [rrh_pkg::TABLE_ENTRIES-1:0]   slot_valid_reg, slot_valid_next;
    logic [rrh_pkg::CFG_W-1:0]           holdoff_reg, expire_reg;

    rrh_pkg::req_t                       req_reg, req_next;
    rrh_pkg::rsp_t                       res_reg, res_next;
    rrh_pkg::rsp_t                       rsp_reg;
    logic [rrh_pkg::SLOT_W-1:0]          hit_idx_reg, hit_idx_next;
    logic [rrh_pkg::SLOT_W-1:0]          free_idx_reg, free_idx_next;
    logic [rrh_pkg::TIME_W-1:0]          hit_age_reg, hit_age_next;
    logic [rrh_pkg::TIME_W-1:0]          hit_time_reg, hit_time_next;
    logic [rrh_pkg::COUNT_W-1:0]         hit_reports_reg, hit_reports_next;

    rrh_pkg::slot_entry_t                slot_mem [rrh_pkg::TABLE_ENTRIES];
    rrh_pkg::slot_entry_t                rd_entry_reg;
    logic                                rd_valid_reg;
    logic [rrh_pkg::SLOT_W-1:0]          cmp_idx_reg;
    logic                                rd_en;
    logic [rrh_pkg::SLOT_W-1:0]          rd_addr;
    logic                                wr_en;
    logic [rrh_pkg::SLOT_W-1:0]          wr_addr;
    rrh_pkg::slot_entry_t                wr_entry;
    logic                                rsp_load;
    logic                                suppress;
    logic [rrh_pkg::COUNT_W-1:0]         new_count;

    rrh_pkg::slot_cmp_t                  cmp;

    rrh_slot_cmp u_slot_cmp (
        .valid  (rd_valid_reg),
        .entry  (rd_entry_reg),
        .block  (req_reg.block_index),
        .now    (req_reg.now_seconds),
        .expire (expire_reg),
        .result (cmp)
    );

    assign req_stall = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;
    assign rd_addr   = rd_cnt_reg[rrh_pkg::SLOT_W-1:0];

    assign suppress  = (hit_age_reg <
                        {{(rrh_pkg::TIME_W - rrh_pkg::CFG_W){1'b0}}, holdoff_reg});
    assign new_count = (hit_reports_reg == rrh_pkg::COUNT_MAX) ?
                       hit_reports_reg : hit_reports_reg + 1'b1;

    always_comb
    begin
        state_next       = state_reg;
        rd_cnt_next      = rd_cnt_reg;
        cmp_pending_next = 1'b0;
        hit_found_next   = hit_found_reg;
        free_found_next  = free_found_reg;
        slot_valid_next  = slot_valid_reg;
        req_next         = req_reg;
        res_next         = res_reg;
        hit_idx_next     = hit_idx_reg;
        free_idx_next    = free_idx_reg;
        hit_age_next     = hit_age_reg;
        hit_time_next    = hit_time_reg;
        hit_reports_next = hit_reports_reg;
        rd_en            = 1'b0;
        wr_en            = 1'b0;
        wr_addr          = hit_idx_reg;
        wr_entry         = '{block:     req_reg.block_index,
                             sent_time: req_reg.now_seconds,
                             reports:   new_count};
        rsp_load         = 1'b0;

        // record first live match and first free slot
        if (cmp_pending_reg)
        begin
            if (cmp.live)
            begin
                if (cmp.match && !hit_found_reg)
                begin
                    hit_found_next   = 1'b1;
                    hit_idx_next     = cmp_idx_reg;
                    hit_age_next     = cmp.age;
                    hit_time_next    = rd_entry_reg.sent_time;
                    hit_reports_next = rd_entry_reg.reports;
                end
            end
            else if (!free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = cmp_idx_reg;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req_data;
                    if (req_data.block_index > req_data.highest_sent)
                    begin
                        res_next   = '{send_now:     1'b0,
                                       block_out:    req_data.block_index,
                                       report_count: '0,
                                       outcome:      rrh_pkg::OUT_RANGE};
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        rd_cnt_next     = '0;
                        hit_found_next  = 1'b0;
                        free_found_next = 1'b0;
                        state_next      = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (rd_cnt_reg != rrh_pkg::CNT_W'(rrh_pkg::TABLE_ENTRIES))
                begin
                    rd_en            = 1'b1;
                    rd_cnt_next      = rd_cnt_reg + 1'b1;
                    cmp_pending_next = 1'b1;
                end
                else
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (hit_found_reg)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = hit_idx_reg;
                    wr_entry = '{block:     req_reg.block_index,
                                 sent_time: suppress ? hit_time_reg : req_reg.now_seconds,
                                 reports:   new_count};
                    res_next = '{send_now:     !suppress,
                                 block_out:    req_reg.block_index,
                                 report_count: new_count,
                                 outcome:      suppress ? rrh_pkg::OUT_SUPPRESSED
                                                        : rrh_pkg::OUT_RESENT};
                end
                else if (free_found_reg)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = free_idx_reg;
                    wr_entry = '{block:     req_reg.block_index,
                                 sent_time: req_reg.now_seconds,
                                 reports:   rrh_pkg::COUNT_W'(1)};
                    slot_valid_next[free_idx_reg] = 1'b1;
                    res_next = '{send_now:     1'b1,
                                 block_out:    req_reg.block_index,
                                 report_count: rrh_pkg::COUNT_W'(1),
                                 outcome:      rrh_pkg::OUT_NEW};
                end
                else
                begin
                    res_next = '{send_now:     1'b1,
                                 block_out:    req_reg.block_index,
                                 report_count: '0,
                                 outcome:      rrh_pkg::OUT_FULL};
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            rd_cnt_reg      <= '0;
            cmp_pending_reg <= 1'b0;
            hit_found_reg   <= 1'b0;
            free_found_reg  <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            slot_valid_reg  <= '0;
            holdoff_reg     <= rrh_pkg::HOLDOFF_RESET;
            expire_reg      <= rrh_pkg::EXPIRE_RESET;
        end
        else
        begin
            state_reg       <= state_next;
            rd_cnt_reg      <= rd_cnt_next;
            cmp_pending_reg <= cmp_pending_next;
            hit_found_reg   <= hit_found_next;
            free_found_reg  <= free_found_next;
            rsp_valid_reg   <= rsp_valid_next;
            slot_valid_reg  <= slot_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    rrh_pkg::REG_HOLDOFF: holdoff_reg <= cfg_data;
                    rrh_pkg::REG_EXPIRE:  expire_reg  <= cfg_data;
                    default:              ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg         <= req_next;
        res_reg         <= res_next;
        hit_idx_reg     <= hit_idx_next;
        free_idx_reg    <= free_idx_next;
        hit_age_reg     <= hit_age_next;
        hit_time_reg    <= hit_time_next;
        hit_reports_reg <= hit_reports_next;
        if (rsp_load)
        begin
            rsp_reg <= res_reg;
        end
    end

    // slot memory: one read port, one write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_entry_reg <= slot_mem[rd_addr];
            rd_valid_reg <= slot_valid_reg[rd_addr];
            cmp_idx_reg  <= rd_addr;
        end
    end

    a_accept_leaves_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg != ST_IDLE)
    ) else $error("accepted request did not start work");

    a_rsp_from_done: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_DONE)
    ) else $error("response raised outside completion");

    a_hit_is_valid: assert property (
        @(posedge clk) disable iff (!rst_n)
        hit_found_reg |-> slot_valid_reg[hit_idx_reg]
    ) else $error("hit recorded on an invalid slot");

endmodule

`default_nettype wire

FILE: hdl/rrh_slot_cmp.sv
// Shared slot compare unit: entry age, expiry check and block match.
`default_nettype none

module rrh_slot_cmp (
    input  wire logic                         valid,
    input  wire rrh_pkg::slot_entry_t         entry,
    input  wire logic [rrh_pkg::BLOCK_W-1:0]  block,
    input  wire logic [rrh_pkg::TIME_W-1:0]   now,
    input  wire logic [rrh_pkg::CFG_W-1:0]    expire,
    output rrh_pkg::slot_cmp_t                result
);

    logic [rrh_pkg::TIME_W-1:0] age;

    assign age = now - entry.sent_time;

    always_comb
    begin
        result.age   = age;
        result.live  = valid &&
                       (age <= {{(rrh_pkg::TIME_W - rrh_pkg::CFG_W){1'b0}}, expire});
        result.match = (entry.block == block);
    end

endmodule

`default_nettype wire

FILE: sim/retransmit_request_holdoff_test.sv
// Testbench for retransmit_request_holdoff: directed and random requests, built-in predictor.
`default_nettype none

module retransmit_request_holdoff_test;

    timeunit 1ns;
    timeprecision 1ps;

    import rrh_pkg::*;

    localparam logic [BLOCK_W-1:0]     BLOCK_MAX      = '1;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B    = 2'd3;
    localparam int                     BATCHES        = 6;
    localparam int                     BATCH_REQUESTS = 275;
    localparam int unsigned            CYCLE_LIMIT    = 1_000_000;
    localparam int                     SETTLE_CYCLES  = 70;
    localparam int                     REPORT_LIMIT   = 10;

    class holdoff_scoreboard;
        logic [CFG_W-1:0]   holdoff;
        logic [CFG_W-1:0]   expiry;
        logic               slot_used    [TABLE_ENTRIES];
        logic [BLOCK_W-1:0] slot_block   [TABLE_ENTRIES];
        logic [TIME_W-1:0]  slot_sent    [TABLE_ENTRIES];
        logic [COUNT_W-1:0] slot_reports [TABLE_ENTRIES];
        rsp_t               decisions_due[$];
        int                 mismatches;

        function new();
            holdoff = HOLDOFF_RESET;
            expiry = EXPIRE_RESET;
            mismatches = 0;
            foreach (slot_used[i])
                slot_used[i] = 1'b0;
        endfunction

        function void set_register(input logic [CFG_INDEX_W-1:0] index,
                                   input logic [CFG_W-1:0] value);
            if (index == REG_HOLDOFF)
                holdoff = value;
            else if (index == REG_EXPIRE)
                expiry = value;
        endfunction

        function int pending();
            return decisions_due.size();
        endfunction

        function void note_request(input req_t r);
            rsp_t              d;
            int                hit;
            int                spare;
            logic [TIME_W-1:0] age;
            hit = -1;
            spare = -1;
            d.send_now = 1'b0;
            d.block_out = r.block_index;
            d.report_count = '0;
            d.outcome = OUT_RANGE;
            if (r.block_index <= r.highest_sent)
            begin
                for (int i = 0; i < TABLE_ENTRIES; i++)
                begin
                    age = r.now_seconds - slot_sent[i];
                    if (slot_used[i] && age <= TIME_W'(expiry))
                    begin
                        if (hit < 0 && slot_block[i] == r.block_index)
                            hit = i;
                    end
                    else if (spare < 0)
                        spare = i;
                end
                if (hit >= 0)
                begin
                    age = r.now_seconds - slot_sent[hit];
                    if (age < TIME_W'(holdoff))
                        d.outcome = OUT_SUPPRESSED;
                    else
                    begin
                        d.outcome = OUT_RESENT;
                        d.send_now = 1'b1;
                        slot_sent[hit] = r.now_seconds;
                    end
                    if (slot_reports[hit] != COUNT_MAX)
                        slot_reports[hit] = slot_reports[hit] + 1'b1;
                    d.report_count = slot_reports[hit];
                end
                else if (spare >= 0)
                begin
                    slot_used[spare] = 1'b1;
                    slot_block[spare] = r.block_index;
                    slot_sent[spare] = r.now_seconds;
                    slot_reports[spare] = COUNT_W'(1);
                    d.outcome = OUT_NEW;
                    d.send_now = 1'b1;
                    d.report_count = COUNT_W'(1);
                end
                else
                begin
                    d.outcome = OUT_FULL;
                    d.send_now = 1'b1;
                end
            end
            decisions_due.push_back(d);
        endfunction

        function void check_response(input rsp_t got);
            rsp_t want;
            logic bad;
            if (decisions_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected response: block=%0d outcome=%0d",
                             got.block_out, got.outcome);
                return;
            end
            want = decisions_due.pop_front();
            bad = (got.send_now !== want.send_now) || (got.block_out !== want.block_out)
                  || (got.report_count !== want.report_count)
                  || (got.outcome !== want.outcome);
            if (bad)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("decision error at %0t: expected send=%0b block=%0d count=%0d outcome=%0d",
                             $realtime, want.send_now, want.block_out, want.report_count,
                             want.outcome);
                    $display("    got send=%0b block=%0d count=%0d outcome=%0d",
                             got.send_now, got.block_out, got.report_count, got.outcome);
                end
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   req_valid;
    logic                   req_stall;
    req_t                   req_data;
    logic                   rsp_valid;
    logic                   rsp_stall;
    rsp_t                   rsp_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_W-1:0]       cfg_data;

    holdoff_scoreboard      book;
    int                     sender_idle_pct;
    int                     rsp_idle_pct;
    int unsigned            cycles = 0;
    logic [TIME_W-1:0]      sim_now = '0;
    logic [BLOCK_W-1:0]     pool_base = '0;

    int unsigned hold_set  [BATCHES] = '{3, 0, 255, 8, 255, 1};
    int unsigned expiry_set[BATCHES] = '{20, 255, 255, 0, 0, 60};
    int unsigned pool_set  [BATCHES] = '{12, 100, 96, 6, 40, 30};

    retransmit_request_holdoff DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge clk)
        rsp_stall <= ($urandom_range(99) < rsp_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && req_valid && !req_stall)
            book.note_request(req_data);
        if (rst_n && rsp_valid && !rsp_stall)
            book.check_response(rsp_data);
    end

    task automatic push_request(input req_t r);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task automatic issue(input logic [BLOCK_W-1:0] blk, input logic [TIME_W-1:0] now,
                         input logic [BLOCK_W-1:0] high);
        req_t r;
        r.block_index = blk;
        r.now_seconds = now;
        r.highest_sent = high;
        push_request(r);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (book.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // leave cfg_valid high; the caller drops it after the last write
    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        book.set_register(index, value);
    endtask

    task automatic apply_timing(input logic [CFG_W-1:0] hold, input logic [CFG_W-1:0] expiry);
        drain();
        write_register(REG_HOLDOFF, hold);
        write_register(REG_EXPIRE, expiry);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic req_t next_request(input int pool);
        req_t r;
        int   pick;
        pick = $urandom_range(99);
        if (pick < 85)
            sim_now = sim_now + $urandom_range(2);
        else if (pick < 97)
            sim_now = sim_now + $urandom_range(300);
        else
            sim_now = $urandom();
        r.now_seconds = sim_now;
        pick = $urandom_range(99);
        if (pick < 75)
            r.block_index = pool_base + BLOCK_W'($urandom_range(pool - 1));
        else if (pick < 90)
            r.block_index = BLOCK_W'($urandom());
        else
            r.block_index = pick[0] ? BLOCK_MAX : '0;
        pick = $urandom_range(99);
        if (pick < 70)
            r.highest_sent = BLOCK_MAX;
        else if (pick < 85)
            r.highest_sent = r.block_index + BLOCK_W'($urandom_range(3));
        else
            r.highest_sent = BLOCK_W'($urandom());
        return r;
    endfunction

    initial
    begin
        book = new();
        sender_idle_pct = 13;
        rsp_idle_pct = 48;
        rst_n <= 1'b0;
        req_valid <= 1'b0;
        req_data <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue('0, 32'd0, '0);
        issue('0, 32'd1, '0);
        issue(BLOCK_MAX, 32'd2, BLOCK_MAX - 1'b1);
        issue(BLOCK_MAX, 32'd3, BLOCK_MAX);
        issue('0, 32'd5, BLOCK_MAX);
        issue('0, 32'd15, BLOCK_MAX);
        issue(BLOCK_MAX, 32'd14, BLOCK_MAX);
        issue(21'h0AAAAA, 32'hFFFF_FFFF, 21'h155555);
        issue(21'h0AAAAA, 32'h0000_0002, BLOCK_MAX);
        issue(21'h155555, 32'h5555_5555, 21'h155555);
        issue(21'h155555, 32'hAAAA_AAAA, 21'h0AAAAA);

        drain();
        write_register(REG_HOLDOFF, 8'h00);
        write_register(REG_EXPIRE, 8'hFF);
        write_register(REG_SPARE_A, 8'hFF);
        write_register(REG_SPARE_B, 8'h00);
        cfg_valid <= 1'b0;
        @(posedge clk);

        issue(21'd7, 32'd1000, BLOCK_MAX);
        issue(21'd7, 32'd1000, BLOCK_MAX);
        issue(21'd7, 32'd1255, 21'd7);
        issue(21'd7, 32'd1511, 21'd7);
        issue(21'd7, 32'd1511, 21'd7);

        for (int b = 0; b < BATCHES; b++)
        begin
            apply_timing(CFG_W'(hold_set[b]), CFG_W'(expiry_set[b]));
            if (b == 2)
            begin
                sender_idle_pct = 48;
                rsp_idle_pct = 13;
            end
            else if (b == 4)
            begin
                sender_idle_pct = 0;
                rsp_idle_pct = 0;
            end
            pool_base = BLOCK_W'($urandom_range(BLOCK_MAX - 128));
            repeat (BATCH_REQUESTS)
                push_request(next_request(pool_set[b]));
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (book.mismatches == 0 && book.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
